// ===== design/lrgd_pkg.sv =====
// Shared constants, handshake structs and saturation helper for the regression fit block.
package lrgd_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int DW = 64;
  localparam int DCW = $clog2(DW);

  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic [15:0] MAX_PASSES_RESET = 16'd1000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_MAX_PASSES = 1'b1;

  localparam logic KIND_FIT = 1'b0;
  localparam logic KIND_PREDICT = 1'b1;
  localparam logic CMD_PREDICT = 1'b1;

  typedef struct packed {
    logic start;
    logic [DW-1:0] dividend;
    logic [CW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DW-1:0] quo;
    logic rem_nz;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = {48'h0, 32'h7FFF_FFFF};
    lo = {{48{1'b1}}, 32'h8000_0000};
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== design/linear_regression_gd_fit.sv =====
// Top level: sample store, pass sequencer and coefficient update for the regression fit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | to block  | in_valid/in_ready  | cmd, x_value, y_value, last_sample
//  out     | from block| out_valid/out_ready| kind, bias_out, weight_out, mse_out,
//          |           |                    | passes_used, prediction
//  cfg     | to block  | cfg_we             | cfg_index, cfg_data (write only)
//
// Load: a sample is written into the sample RAMs. Predict: the shared multiplier forms w * x.
// Fit over n samples: each pass takes six steps a sample, three divisions by n,
// a 16-step shift-add rate scaling and the update.
// Reset (rst, synchronous) clears sequencer, sample count and out_valid and restores
// bias, weight and the registers to their defaults; the RAMs are not cleared.
// in_ready is high only in idle; an untaken result holds the next finish step, loads go in.
module linear_regression_gd_fit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic signed [31:0] bias_out,
  output logic signed [31:0] weight_out,
  output logic [47:0]        mse_out,
  output logic [15:0]        passes_used,
  output logic signed [31:0] prediction,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PMUL  = 15'b000000000000010,
    S_PRES  = 15'b000000000000100,
    S_START = 15'b000000000001000,
    S_RD    = 15'b000000000010000,
    S_WX    = 15'b000000000100000,
    S_ERR   = 15'b000000001000000,
    S_MXE   = 15'b000000010000000,
    S_MEE   = 15'b000000100000000,
    S_ACC   = 15'b000001000000000,
    S_DIV   = 15'b000010000000000,
    S_DIVW  = 15'b000100000000000,
    S_UPD   = 15'b001000000000000,
    S_APPLY = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] learning_rate;
  logic [15:0] max_passes;

  // coefficients and fit bookkeeping
  logic signed [31:0]       bias;
  logic signed [31:0]       weight;
  logic [lrgd_pkg::CW-1:0]  sample_count;
  logic [lrgd_pkg::CW-1:0]  idx;
  logic [15:0]              passes;
  logic [47:0]              mse;
  logic [47:0]              last_mse;
  logic                     prev_valid;
  logic                     fin_kind;
  logic signed [31:0]       pred;

  // per-sample datapath
  logic signed [31:0] xr;
  logic signed [31:0] yr;
  logic signed [32:0] err;
  logic signed [63:0] sb;
  logic signed [63:0] sw;
  logic [63:0]        sq;
  logic signed [63:0] mb;
  logic signed [63:0] mw;
  logic [1:0]         div_sel;
  logic signed [79:0] accb;
  logic signed [79:0] accw;
  logic [3:0]         k;

  // RAM
  logic                    ram_we;
  logic [lrgd_pkg::AW-1:0] ram_raddr;
  logic [31:0]             x_rdata;
  logic [31:0]             y_rdata;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mp;

  // divider
  lrgd_pkg::div_req_t div_req;
  lrgd_pkg::div_rsp_t div_rsp;

  logic                    in_acc;
  logic                    full;
  logic signed [79:0]      mp80;
  logic signed [79:0]      psum;
  logic signed [31:0]      p_sat;
  logic signed [65:0]      mp_sh;
  logic signed [63:0]      div_val;
  logic                    div_neg;
  logic [63:0]             q_adj;
  logic signed [63:0]      q_signed;
  logic [lrgd_pkg::CW-1:0] idx_next;
  logic [15:0]             passes_next;
  logic [47:0]             mse_sat;
  logic                    stop;

  assign in_ready = state == S_IDLE;
  assign in_acc   = in_valid && in_ready;
  assign full     = sample_count == lrgd_pkg::CW'(lrgd_pkg::MAX_SAMPLES);
  assign ram_we   = in_acc && cmd != lrgd_pkg::CMD_PREDICT && !full;
  assign ram_raddr = idx[lrgd_pkg::AW-1:0];

  lrgd_ram #(.WIDTH(32), .DEPTH(lrgd_pkg::MAX_SAMPLES)) u_x_ram (
    .clk(clk), .we(ram_we), .waddr(sample_count[lrgd_pkg::AW-1:0]), .wdata(x_value),
    .raddr(ram_raddr), .rdata(x_rdata)
  );

  lrgd_ram #(.WIDTH(32), .DEPTH(lrgd_pkg::MAX_SAMPLES)) u_y_ram (
    .clk(clk), .we(ram_we), .waddr(sample_count[lrgd_pkg::AW-1:0]), .wdata(y_value),
    .raddr(ram_raddr), .rdata(y_rdata)
  );

  // select multiplier operands by step: w*x, then x*e, then e*e
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PMUL: begin
        mul_a = {weight[31], weight};
        mul_b = {xr[31], xr};
      end
      S_WX: begin
        mul_a = {weight[31], weight};
        mul_b = {x_rdata[31], x_rdata};
      end
      S_MXE: begin
        mul_a = {xr[31], xr};
        mul_b = err;
      end
      S_MEE: begin
        mul_a = err;
        mul_b = err;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lrgd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mp));

  // prediction from the product in hand: sat32(bias + floor(w * x / 2^16))
  assign mp80  = {{14{mp[65]}}, mp};
  assign psum  = (mp80 >>> 16) + $signed({{48{bias[31]}}, bias});
  assign p_sat = lrgd_pkg::sat32(psum);
  assign mp_sh = mp >>> 16;

  // floor division of signed sums: divide the magnitude, round away from zero if negative
  always_comb begin
    case (div_sel)
      2'd0:    div_val = sb;
      2'd1:    div_val = sw;
      default: div_val = sq;
    endcase
  end
  assign div_neg  = div_sel != 2'd2 && div_val[63];
  assign q_adj    = div_rsp.quo + {63'h0, div_rsp.rem_nz};
  assign q_signed = div_neg ? -$signed(q_adj) : $signed(div_rsp.quo);

  assign div_req.start    = state == S_DIV;
  assign div_req.dividend = div_neg ? 64'(-div_val) : div_val;
  assign div_req.divisor  = sample_count;

  lrgd_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign idx_next    = idx + 1'b1;
  assign passes_next = passes + 1'b1;
  assign mse_sat     = |div_rsp.quo[63:48] ? {48{1'b1}} : div_rsp.quo[47:0];
  assign stop        = (prev_valid && mse == last_mse) || passes_next == max_passes;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      learning_rate <= lrgd_pkg::LR_RESET;
      max_passes    <= lrgd_pkg::MAX_PASSES_RESET;
      bias          <= lrgd_pkg::ONE_Q16;
      weight        <= lrgd_pkg::ONE_Q16;
      sample_count  <= '0;
      out_valid     <= 1'b0;
      prev_valid    <= 1'b0;
      passes        <= '0;
      idx           <= '0;
      div_sel       <= '0;
      k             <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lrgd_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data;
          lrgd_pkg::REG_MAX_PASSES:    max_passes    <= cfg_data;
          default: ;
        endcase
      end

      // drop the taken result; the finish step reloads the register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            xr <= x_value;
            if (cmd == lrgd_pkg::CMD_PREDICT) begin
              state <= S_PMUL;
            end else begin
              if (!full) begin
                sample_count <= sample_count + 1'b1;
              end
              // a last flag starts the fit even when the sample was dropped
              if (last_sample) begin
                state <= S_START;
              end
            end
          end
        end
        S_PMUL: state <= S_PRES;
        S_PRES: begin
          pred     <= p_sat;
          fin_kind <= lrgd_pkg::KIND_PREDICT;
          state    <= S_FIN;
        end
        S_START: begin
          fin_kind   <= lrgd_pkg::KIND_FIT;
          passes     <= '0;
          mse        <= '0;
          prev_valid <= 1'b0;
          idx        <= '0;
          sb         <= '0;
          sw         <= '0;
          sq         <= '0;
          if (sample_count == '0 || max_passes == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_WX;
        S_WX: begin
          xr    <= x_rdata;
          yr    <= y_rdata;
          state <= S_ERR;
        end
        S_ERR: begin
          err   <= {yr[31], yr} - {p_sat[31], p_sat};
          state <= S_MXE;
        end
        S_MXE: begin
          sb    <= sb + {{31{err[32]}}, err};
          state <= S_MEE;
        end
        S_MEE: begin
          sw    <= sw + mp_sh[63:0];
          state <= S_ACC;
        end
        S_ACC: begin
          sq  <= sq + {14'h0, mp[65:16]};
          idx <= idx_next;
          if (idx_next == sample_count) begin
            div_sel <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_RD;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) begin
            case (div_sel)
              2'd0:    mb  <= q_signed;
              2'd1:    mw  <= q_signed;
              default: mse <= mse_sat;
            endcase
            if (div_sel == 2'd2) begin
              accb  <= '0;
              accw  <= '0;
              k     <= '0;
              state <= S_UPD;
            end else begin
              div_sel <= div_sel + 1'b1;
              state   <= S_DIV;
            end
          end
        end
        S_UPD: begin
          // scale the mean gradients by the rate, one rate bit a cycle
          if (learning_rate[k]) begin
            accb <= accb + ({{16{mb[63]}}, mb} <<< k);
            accw <= accw + ({{16{mw[63]}}, mw} <<< k);
          end
          k <= k + 1'b1;
          if (k == 4'd15) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          bias   <= lrgd_pkg::sat32($signed({{48{bias[31]}}, bias}) + (accb >>> 15));
          weight <= lrgd_pkg::sat32($signed({{48{weight[31]}}, weight}) + (accw >>> 15));
          passes     <= passes_next;
          last_mse   <= mse;
          prev_valid <= 1'b1;
          idx        <= '0;
          sb         <= '0;
          sw         <= '0;
          sq         <= '0;
          state      <= stop ? S_FIN : S_RD;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            kind      <= fin_kind;
            if (fin_kind == lrgd_pkg::KIND_PREDICT) begin
              bias_out    <= '0;
              weight_out  <= '0;
              mse_out     <= '0;
              passes_used <= '0;
              prediction  <= pred;
            end else begin
              bias_out     <= bias;
              weight_out   <= weight;
              mse_out      <= mse;
              passes_used  <= passes;
              prediction   <= '0;
              sample_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= lrgd_pkg::CW'(lrgd_pkg::MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_pred_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lrgd_pkg::KIND_PREDICT |->
      bias_out == '0 && weight_out == '0 && mse_out == '0 && passes_used == '0)
    else $error("prediction result carries fit fields");

  a_fit_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == lrgd_pkg::KIND_FIT |->
      prediction == '0 && passes_used <= max_passes)
    else $error("fit result inconsistent");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIVW)
    else $error("divider finished outside its wait step");

  a_fin_count: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && fin_kind == lrgd_pkg::KIND_FIT && (!out_valid || out_ready)
      |=> sample_count == '0)
    else $error("sample count not cleared after fit");

endmodule

// ===== design/lrgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lrgd_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
module lrgd_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/lrgd_div.sv =====
// Iterative restoring divider, one quotient bit a cycle, unsigned operands.
module lrgd_div (
  input  logic              clk,
  input  logic              rst,
  input  lrgd_pkg::div_req_t req,
  output lrgd_pkg::div_rsp_t rsp
);

  logic [lrgd_pkg::DW-1:0]  quo;
  logic [lrgd_pkg::CW-1:0]  rem;
  logic [lrgd_pkg::CW-1:0]  dvs;
  logic [lrgd_pkg::DCW-1:0] cnt;
  logic                     busy;
  logic                     done;
  logic [lrgd_pkg::CW:0]    rem_sh;
  logic                     fits;

  assign rem_sh = {rem, quo[lrgd_pkg::DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        // shift in the next dividend bit, subtract where the divisor fits
        rem <= fits ? lrgd_pkg::CW'(rem_sh - {1'b0, dvs}) : rem_sh[lrgd_pkg::CW-1:0];
        quo <= {quo[lrgd_pkg::DW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == lrgd_pkg::DCW'(lrgd_pkg::DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.quo    = quo;
  assign rsp.rem_nz = rem != '0;

endmodule

// ===== verif/linear_regression_gd_fit_checker.sv =====
// Scoreboard for the regression fit block: mirrors its arithmetic and compares every result.
module linear_regression_gd_fit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               last_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               kind,
  input  logic signed [31:0] bias_out,
  input  logic signed [31:0] weight_out,
  input  logic [47:0]        mse_out,
  input  logic [15:0]        passes_used,
  input  logic signed [31:0] prediction,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [31:0] bias;
    logic [31:0] weight;
    logic [47:0] mse;
    logic [15:0] passes;
    logic [31:0] pred;
  } fit_result_t;

  localparam longint unsigned MSE_CAP = 64'h0000_FFFF_FFFF_FFFF;

  fit_result_t    awaited[$];
  longint         xs[lrgd_pkg::MAX_SAMPLES];
  longint         ys[lrgd_pkg::MAX_SAMPLES];
  int             n_loaded;
  longint         coef_b;
  longint         coef_w;
  longint         rate;
  int             pass_limit;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint line_at(longint x);
    return sat(coef_b + floor_div(coef_w * x, 65536));
  endfunction

  // One batch pass: all errors from the coefficients at the start, then update both.
  function automatic longint unsigned grad_pass(int n);
    longint sb, sw, e, mb, mw;
    longint unsigned ae, sq;
    sb = 0;
    sw = 0;
    sq = 0;
    for (int i = 0; i < n; i++) begin
      e = ys[i] - line_at(xs[i]);
      ae = (e < 0) ? -e : e;
      sb += e;
      sw += floor_div(xs[i] * e, 65536);
      sq += (ae * ae) >> 16;
    end
    mb = floor_div(sb, n);
    mw = floor_div(sw, n);
    coef_b = sat(coef_b + floor_div(mb * rate, 32768));
    coef_w = sat(coef_w + floor_div(mw * rate, 32768));
    sq = sq / n;
    return (sq > MSE_CAP) ? MSE_CAP : sq;
  endfunction

  function automatic fit_result_t fit_all();
    fit_result_t r;
    longint unsigned mse, prev;
    int passes;
    bit have_prev;
    mse = 0;
    prev = 0;
    passes = 0;
    have_prev = 0;
    if (n_loaded > 0) begin
      while (passes < pass_limit) begin
        mse = grad_pass(n_loaded);
        passes++;
        if (have_prev && mse == prev) break;
        prev = mse;
        have_prev = 1;
      end
    end
    n_loaded = 0;
    r.kind = lrgd_pkg::KIND_FIT;
    r.bias = coef_b[31:0];
    r.weight = coef_w[31:0];
    r.mse = mse[47:0];
    r.passes = passes[15:0];
    r.pred = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    fit_result_t got, want;
    if (rst) begin
      awaited.delete();
      n_loaded = 0;
      coef_b = 65536;
      coef_w = 65536;
      rate = longint'(lrgd_pkg::LR_RESET);
      pass_limit = int'(lrgd_pkg::MAX_PASSES_RESET);
    end else begin
      // Results first: anything leaving now was caused by an earlier item.
      if (out_valid && out_ready) begin
        got = '{kind, bias_out, weight_out, mse_out, passes_used, prediction};
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind=%0d", kind);
        end else begin
          want = awaited.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch exp k=%0d b=%h w=%h m=%h p=%0d y=%h",
                        " / got k=%0d b=%h w=%h m=%h p=%0d y=%h"},
                       want.kind, want.bias, want.weight, want.mse, want.passes, want.pred,
                       got.kind, got.bias, got.weight, got.mse, got.passes, got.pred);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == lrgd_pkg::CMD_PREDICT) begin
          want = '{lrgd_pkg::KIND_PREDICT, '0, '0, '0, '0, '0};
          want.pred = 32'(line_at(longint'(x_value)));
          awaited.push_back(want);
        end else begin
          // Drop the sample once the store is full; the last flag still counts.
          if (n_loaded < lrgd_pkg::MAX_SAMPLES) begin
            xs[n_loaded] = longint'(x_value);
            ys[n_loaded] = longint'(y_value);
            n_loaded++;
          end
          if (last_sample) awaited.push_back(fit_all());
        end
      end
      if (cfg_we) begin
        if (cfg_index == lrgd_pkg::REG_LEARNING_RATE) rate = longint'(cfg_data);
        else pass_limit = int'(cfg_data);
      end
    end
    pending = awaited.size();
  end

  initial errors = 0;
endmodule

// ===== verif/linear_regression_gd_fit_test.sv =====
// Testbench top: clock, reset, stimulus and verdict for the regression fit block.
module linear_regression_gd_fit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_LOAD = 1'b0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_LOAD;
  logic signed [31:0] x_value = '0;
  logic signed [31:0] y_value = '0;
  logic               last_sample = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic signed [31:0] bias_out;
  logic signed [31:0] weight_out;
  logic [47:0]        mse_out;
  logic [15:0]        passes_used;
  logic signed [31:0] prediction;
  logic               cfg_we = 1'b0;
  logic               cfg_index = lrgd_pkg::REG_LEARNING_RATE;
  logic [15:0]        cfg_data = '0;
  int                 errors;
  int                 pending;

  // Sender idling control and the receiver's long hold-off request.
  bit                 steady = 0;
  bit                 hold_req = 0;
  int                 items_sent = 0;

  always #6 clk = ~clk;

  linear_regression_gd_fit dut (.*);

  linear_regression_gd_fit_checker scoreboard (.*);

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one item from a falling edge and hold it until the block takes it.
  task automatic offer(logic c, logic signed [31:0] x, logic signed [31:0] y, logic last);
    int g;
    g = steady ? 0 : gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    cmd = c;
    x_value = x;
    y_value = y;
    last_sample = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  // Wait until every outstanding result is back, then let the block settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_index = idx;
    cfg_data = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly small values near the origin so fits converge; sometimes full range.
  function automatic logic signed [31:0] sample_val();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 524288)) - 262144;
  endfunction

  task automatic load_set(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        offer(lrgd_pkg::CMD_PREDICT, sample_val(), $urandom, 1'($urandom));
      offer(CMD_LOAD, sample_val(), sample_val(), i == n - 1);
    end
  endtask

  // Receiver: random stalls, plus one long hold when asked for.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        g = gap_len();
        if (g > 0) begin
          out_ready = 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  initial begin
    #(50_000_000);
    $display("FAIL linear_regression_gd_fit");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: predictions with the reset coefficients at zero and at the x extremes.
    offer(lrgd_pkg::CMD_PREDICT, 32'sh0000_0000, 32'sh7FFF_FFFF, 1'b1);
    offer(lrgd_pkg::CMD_PREDICT, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
    offer(lrgd_pkg::CMD_PREDICT, 32'sh8000_0000, 32'sh8000_0000, 1'b0);

    // Zero pass limit: coefficients hold, mse and pass count stay zero.
    write_reg(lrgd_pkg::REG_MAX_PASSES, 16'd0);
    write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'd65535);
    offer(CMD_LOAD, 32'sh0002_0000, 32'sh0005_0000, 1'b0);
    offer(CMD_LOAD, 32'sh0003_0000, 32'sh0007_0000, 1'b1);

    // Zero rate with the widest limit: the mse repeats, so it stops early.
    write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'd0);
    write_reg(lrgd_pkg::REG_MAX_PASSES, 16'd65535);
    offer(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    offer(CMD_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);

    // Full rate on extreme samples: drive the coefficients and mse into saturation.
    write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'd65535);
    write_reg(lrgd_pkg::REG_MAX_PASSES, 16'd4);
    offer(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    offer(CMD_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    offer(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    offer(lrgd_pkg::CMD_PREDICT, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
    offer(lrgd_pkg::CMD_PREDICT, 32'sh8000_0000, 32'sh0, 1'b1);

    // Single sample set at a moderate rate.
    write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'd655);
    write_reg(lrgd_pkg::REG_MAX_PASSES, 16'd6);
    offer(CMD_LOAD, 32'sh0001_8000, 32'sh0004_0000, 1'b1);
    offer(lrgd_pkg::CMD_PREDICT, 32'sh0001_0000, 32'sh0, 1'b0);

    // Full store: overflow samples are dropped, their last flag still fits.
    write_reg(lrgd_pkg::REG_MAX_PASSES, 16'd1);
    steady = 1;
    for (int i = 0; i < lrgd_pkg::MAX_SAMPLES + 5; i++)
      offer(CMD_LOAD, sample_val(), sample_val(), i == lrgd_pkg::MAX_SAMPLES + 4);
    steady = 0;
    offer(lrgd_pkg::CMD_PREDICT, 32'sh0000_8000, 32'sh0, 1'b0);
    drain();
    items_sent = 0;

    // Random phases: new settings every few sets, with pressure mixed in.
    for (int phase = 0; items_sent < 550; phase++) begin
      case ($urandom_range(0, 3))
        0: write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'($urandom_range(0, 65535)));
        1: write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'($urandom_range(1, 4000)));
        2: write_reg(lrgd_pkg::REG_LEARNING_RATE, (phase % 2) ? 16'd65535 : 16'd0);
        default: write_reg(lrgd_pkg::REG_LEARNING_RATE, 16'd655);
      endcase
      write_reg(lrgd_pkg::REG_MAX_PASSES, 16'($urandom_range(0, 12)));
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Long receiver hold while predictions keep coming: the block backs up.
        hold_req = 1;
        for (int i = 0; i < 12; i++)
          offer(lrgd_pkg::CMD_PREDICT, sample_val(), $urandom, 1'($urandom));
      end
      for (int s = 0; s < 8; s++) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4))
            offer(lrgd_pkg::CMD_PREDICT, $urandom, $urandom, 1'($urandom));
        end else begin
          load_set($urandom_range(1, 8));
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
    end

    drain();
    repeat (300) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS linear_regression_gd_fit");
    end else begin
      $display("FAIL linear_regression_gd_fit");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/lrgd_pkg.sv
design/lrgd_ram.sv
design/lrgd_mul.sv
design/lrgd_div.sv
design/linear_regression_gd_fit.sv
verif/linear_regression_gd_fit_checker.sv
verif/linear_regression_gd_fit_test.sv
